>>> hdl/fsg_pkg.sv
package fsg_pkg;

    // Grid size defaults
    localparam int GRID_ROWS_DEF = 64;
    localparam int GRID_COLS_DEF = 64;

    // Random bit generator
    localparam logic [15:0] SEED_RESET = 16'd44257;
    localparam logic [15:0] LFSR_TAPS  = 16'hB400;

    // Saturation limit of the move counter
    localparam int          MOVED_W   = 13;
    localparam logic [12:0] MOVED_MAX = 13'd8191;

    // Stream widths
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 48;

    // Operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_TICK   = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    // One grid cell as stored
    typedef struct packed {
        logic        occ;
        logic [31:0] color;
    } cell_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RDWAIT,
        ST_ROW,
        ST_RD,
        ST_EVAL,
        ST_RESP
    } state_t;

endpackage

>>> hdl/fsg_grid_mem.sv
module fsg_grid_mem #(
    parameter int ADDR_W = 12
) (
    input  logic                  aclk,
    input  logic                  we,
    input  logic [ADDR_W-1:0]     waddr,
    input  fsg_pkg::cell_t        wdata,
    input  logic [ADDR_W-1:0]     raddr_a,
    output fsg_pkg::cell_t        rdata_a,
    input  logic [ADDR_W-1:0]     raddr_b,
    output fsg_pkg::cell_t        rdata_b
);

    localparam int DEPTH = 1 << ADDR_W;

    fsg_pkg::cell_t mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Two registered read ports
    always_ff @(posedge aclk) begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

>>> hdl/falling_sand_grid_step.sv
// Falling-sand grid of GRID_ROWS x GRID_COLS cells, each empty or holding a particle
// with a 32-bit RGBA color, kept in an on-chip memory with one write and two read
// ports. Every input transaction returns exactly one result transaction. An insert
// writes the memory while idle and a read waits for the registered memory output
// before the result is queued. A tick visits every cell of rows GRID_ROWS-2 down to
// 0: for each row it prefetches the first cell below, then reads and evaluates each
// cell in turn, paced by the read latency of the memory and its single write
// port (a move writes the destination, the source is cleared in the following
// cycle). The random bit generator advances once per visited cell. After reset the
// block sweeps all 2^(clog2(GRID_ROWS)+clog2(GRID_COLS)) entries (4096 at 64x64) of
// the memory to empty, one entry per cycle; s_tready stays low meanwhile, while seed
// writes on the cfg channel are taken at any time. The seed must only be written
// while no transaction is in progress; a zero seed loads 1.
module falling_sand_grid_step #(
    parameter int GRID_ROWS = fsg_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS = fsg_pkg::GRID_COLS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // opcode[1:0], cell_column[7:2], cell_row[13:8], particle_color[45:14], zeros
    input  logic [fsg_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // cell_occupied[0], cell_color[32:1], moved_count[45:33], zeros
    output logic [fsg_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [15:0]                   cfg_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready
);

    localparam int RW     = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
    localparam int CW     = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
    localparam int ADDR_W = RW + CW;

    localparam logic [RW-1:0] ROW_START = RW'(GRID_ROWS - 2);
    localparam logic [CW-1:0] COL_LAST  = CW'(GRID_COLS - 1);

    // Input fields
    logic [1:0]  in_opcode;
    logic [5:0]  in_column;
    logic [5:0]  in_row;
    logic [31:0] in_color;
    logic [7:0]  in_row8;
    logic [7:0]  in_col8;
    logic        in_inside;
    logic [ADDR_W-1:0] in_addr;
    logic        s_accept;

    assign in_opcode = s_tdata[1:0];
    assign in_column = s_tdata[7:2];
    assign in_row    = s_tdata[13:8];
    assign in_color  = s_tdata[45:14];
    assign in_row8   = {2'b00, in_row};
    assign in_col8   = {2'b00, in_column};
    assign in_inside = ({3'b000, in_row} < 9'(GRID_ROWS)) &&
                       ({3'b000, in_column} < 9'(GRID_COLS));
    assign in_addr   = {in_row8[RW-1:0], in_col8[CW-1:0]};
    assign s_accept  = s_tvalid && s_tready;

    // Registers
    fsg_pkg::state_t       state_reg, state_next;
    logic [ADDR_W-1:0]     clr_cnt_reg, clr_cnt_next;
    logic [15:0]           lfsr_reg, lfsr_next;
    logic [RW-1:0]         row_reg, row_next;
    logic [CW-1:0]         col_reg, col_next;
    logic                  left_reg, left_next;
    logic                  mid_reg, mid_next;
    logic                  pend_reg, pend_next;
    logic [ADDR_W-1:0]     pend_addr_reg, pend_addr_next;
    logic                  inside_reg, inside_next;
    logic [12:0]           moved_reg, moved_next;
    logic                  res_occ_reg, res_occ_next;
    logic [31:0]           res_color_reg, res_color_next;
    logic                  m_valid_reg, m_valid_next;
    logic [fsg_pkg::M_DATA_W-1:0] m_data_reg, m_data_next;

    // Memory ports
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    fsg_pkg::cell_t        mem_wdata;
    logic [ADDR_W-1:0]     mem_raddr_a;
    logic [ADDR_W-1:0]     mem_raddr_b;
    fsg_pkg::cell_t        q_a;
    fsg_pkg::cell_t        q_b;

    fsg_grid_mem #(
        .ADDR_W (ADDR_W)
    ) u_mem (
        .aclk    (aclk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .raddr_a (mem_raddr_a),
        .rdata_a (q_a),
        .raddr_b (mem_raddr_b),
        .rdata_b (q_b)
    );

    // Cell evaluation during a tick
    logic          last_col;
    logic          right_occ;
    logic          rbit;
    logic          first_free;
    logic          second_free;
    logic          move_dn;
    logic          move_1;
    logic          move_2;
    logic          move_any;
    logic          dest_left;
    logic          dest_right;
    logic [CW-1:0] dest_col;
    logic [RW-1:0] row_below;
    logic          out_free;

    assign last_col    = (col_reg == COL_LAST);
    assign right_occ   = last_col ? 1'b1 : q_b.occ;
    assign rbit        = lfsr_reg[0];
    assign first_free  = rbit ? !left_reg : !right_occ;
    assign second_free = rbit ? !right_occ : !left_reg;
    assign move_dn     = q_a.occ && !mid_reg;
    assign move_1      = q_a.occ && mid_reg && first_free;
    assign move_2      = q_a.occ && mid_reg && !first_free && second_free;
    assign move_any    = move_dn || move_1 || move_2;
    assign dest_left   = (move_1 && rbit) || (move_2 && !rbit);
    assign dest_right  = (move_1 && !rbit) || (move_2 && rbit);
    assign dest_col    = dest_left ? (col_reg - 1'b1) :
                         dest_right ? (col_reg + 1'b1) : col_reg;
    assign row_below   = row_reg + 1'b1;
    assign out_free    = !m_valid_reg || m_tready;

    // Take a command only while idle
    assign s_tready    = (state_reg == fsg_pkg::ST_IDLE);

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            fsg_pkg::ST_CLEAR: begin
                if (clr_cnt_reg == {ADDR_W{1'b1}}) begin
                    state_next = fsg_pkg::ST_IDLE;
                end
            end
            fsg_pkg::ST_IDLE: begin
                if (s_accept) begin
                    case (in_opcode)
                        fsg_pkg::OP_TICK: state_next = fsg_pkg::ST_ROW;
                        fsg_pkg::OP_READ: state_next = fsg_pkg::ST_RDWAIT;
                        default:          state_next = fsg_pkg::ST_RESP;
                    endcase
                end
            end
            fsg_pkg::ST_RDWAIT: state_next = fsg_pkg::ST_RESP;
            fsg_pkg::ST_ROW:    state_next = fsg_pkg::ST_RD;
            fsg_pkg::ST_RD:     state_next = fsg_pkg::ST_EVAL;
            fsg_pkg::ST_EVAL: begin
                if (!last_col) begin
                    state_next = fsg_pkg::ST_RD;
                end else if (row_reg == '0) begin
                    state_next = fsg_pkg::ST_RESP;
                end else begin
                    state_next = fsg_pkg::ST_ROW;
                end
            end
            fsg_pkg::ST_RESP: begin
                if (out_free) begin
                    state_next = fsg_pkg::ST_IDLE;
                end
            end
            default: state_next = fsg_pkg::ST_CLEAR;
        endcase
    end

    // Datapath and memory control
    always_comb begin
        clr_cnt_next   = clr_cnt_reg;
        lfsr_next      = lfsr_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        left_next      = left_reg;
        mid_next       = mid_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        inside_next    = inside_reg;
        moved_next     = moved_reg;
        res_occ_next   = res_occ_reg;
        res_color_next = res_color_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        mem_we         = 1'b0;
        mem_waddr      = pend_addr_reg;
        mem_wdata      = '0;
        mem_raddr_a    = {row_reg, col_reg};
        mem_raddr_b    = {row_below, col_reg + 1'b1};

        // Retire a taken result
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        // Clear the source cell of the last move
        if (pend_reg) begin
            mem_we    = 1'b1;
            mem_waddr = pend_addr_reg;
            mem_wdata = '0;
        end

        unique case (state_reg)
            fsg_pkg::ST_CLEAR: begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            fsg_pkg::ST_IDLE: begin
                mem_raddr_a = in_addr;
                if (s_tvalid) begin
                    inside_next    = in_inside;
                    moved_next     = '0;
                    res_occ_next   = 1'b0;
                    res_color_next = '0;
                    row_next       = ROW_START;
                    col_next       = '0;
                    if (in_opcode == fsg_pkg::OP_INSERT && in_inside) begin
                        mem_we          = 1'b1;
                        mem_waddr       = in_addr;
                        mem_wdata.occ   = 1'b1;
                        mem_wdata.color = in_color;
                    end
                end
            end
            fsg_pkg::ST_RDWAIT: begin
                res_occ_next   = inside_reg && q_a.occ;
                res_color_next = inside_reg ? q_a.color : 32'd0;
            end
            fsg_pkg::ST_ROW: begin
                // Prefetch the first cell below; the left edge counts as occupied
                mem_raddr_b = {row_below, {CW{1'b0}}};
                left_next   = 1'b1;
            end
            fsg_pkg::ST_RD: begin
                if (col_reg == '0) begin
                    mid_next = q_b.occ;
                end
            end
            fsg_pkg::ST_EVAL: begin
                lfsr_next = (lfsr_reg >> 1) ^ (rbit ? fsg_pkg::LFSR_TAPS : 16'd0);
                if (move_any) begin
                    mem_we          = 1'b1;
                    mem_waddr       = {row_below, dest_col};
                    mem_wdata.occ   = 1'b1;
                    mem_wdata.color = q_a.color;
                    pend_next       = 1'b1;
                    pend_addr_next  = {row_reg, col_reg};
                    if (moved_reg != fsg_pkg::MOVED_MAX) begin
                        moved_next = moved_reg + 1'b1;
                    end
                end
                // Slide the window over the row below
                left_next = mid_reg || move_dn;
                mid_next  = right_occ || dest_right;
                if (last_col) begin
                    col_next = '0;
                    row_next = row_reg - 1'b1;
                end else begin
                    col_next = col_reg + 1'b1;
                end
            end
            fsg_pkg::ST_RESP: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {2'b00, moved_reg, res_color_reg, res_occ_reg};
                end
            end
            default: begin
                clr_cnt_next = '0;
            end
        endcase

        // Load a new seed
        if (cfg_valid) begin
            lfsr_next = (cfg_data == 16'd0) ? 16'd1 : cfg_data;
        end
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= fsg_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
            lfsr_reg    <= fsg_pkg::SEED_RESET;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            lfsr_reg    <= lfsr_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        row_reg       <= row_next;
        col_reg       <= col_next;
        left_reg      <= left_next;
        mid_reg       <= mid_next;
        pend_addr_reg <= pend_addr_next;
        inside_reg    <= inside_next;
        moved_reg     <= moved_next;
        res_occ_reg   <= res_occ_next;
        res_color_reg <= res_color_next;
        m_data_reg    <= m_data_next;
    end

endmodule
